// ----- hw/rtl/pee_pkg.sv -----
package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_CHAR  = 3'd1;
    localparam logic [2:0] ERR_UNDER = 3'd2;
    localparam logic [2:0] ERR_OVER  = 3'd3;
    localparam logic [2:0] ERR_DIV0  = 3'd4;
    localparam logic [2:0] ERR_EMPTY = 3'd5;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_DIV = 2'd0,
        OP_POW = 2'd1
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } alu_rsp_t;

endpackage

// ----- hw/rtl/postfix_expression_evaluator.sv -----
// postfix expression evaluator
// input channel s_axis: one character item per transfer, tdata = char_code[7:0],
// tlast marks the last character of an expression
// output channel m_axis: one item per expression, sent after the last character,
// tdata = value[31:0], error[34:32], zero padded to 40 bits
// the operand stack lives in a single-port synchronous ram; an operator reads
// its two operands one after the other and writes the result back
// a new character is taken only in the idle state, once the previous one is done;
// / uses a 32-step divider, ^ square and multiply, one exponent bit per cycle
// the last character then reads the top of stack and loads the output register,
// after first pushing the number that it ends, if any
// reset clears the count, pending number and error; stack contents need no clear
// when the receiver stalls, the result waits in the output register and the
// next expression's characters are still taken until its own result is due
module postfix_expression_evaluator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // value[31:0], error[34:32]
);

    localparam int PW = pee_pkg::PTR_W;
    localparam int CW = pee_pkg::CNT_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FLUSH  = 10'b0000000010,
        S_DISP   = 10'b0000000100,
        S_RD1    = 10'b0000001000,
        S_RD2    = 10'b0000010000,
        S_CALC   = 10'b0000100000,
        S_WAIT   = 10'b0001000000,
        S_PUSH   = 10'b0010000000,
        S_TOP    = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    logic [31:0] mem [pee_pkg::STACK_DEPTH];
    logic [31:0] rd_data;
    logic        we;
    logic [PW-1:0] addr;
    logic [31:0] wd;

    state_t      state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic        act_reg, act_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  ch_reg, ch_next;
    logic        last_reg, last_next;
    logic [31:0] rhs_reg, rhs_next;
    logic [31:0] lhs_reg, lhs_next;
    logic [31:0] res_reg, res_next;
    logic        ov_reg, ov_next;
    logic [39:0] od_reg, od_next;

    pee_pkg::alu_req_t areq;
    pee_pkg::alu_rsp_t arsp;

    logic        is_digit;
    logic        is_space;
    logic        is_op;
    logic [63:0] prod;
    logic [35:0] num10;
    logic [31:0] push_val;
    logic        push_en;

    pee_alu u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (areq),
        .rsp    (arsp)
    );

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wd;
        end
        rd_data <= mem[addr];
    end

    assign is_digit = (ch_reg >= pee_pkg::CH_ZERO) && (ch_reg <= pee_pkg::CH_NINE);
    assign is_space = (ch_reg == pee_pkg::CH_SPACE) || ((ch_reg >= 8'd9) && (ch_reg <= 8'd13));
    assign is_op = (ch_reg == pee_pkg::CH_PLUS) || (ch_reg == pee_pkg::CH_MINUS)
                || (ch_reg == pee_pkg::CH_STAR) || (ch_reg == pee_pkg::CH_SLASH)
                || (ch_reg == pee_pkg::CH_CARET);
    assign prod  = lhs_reg * rhs_reg;
    assign num10 = {num_reg, 3'b000} + {3'b000, num_reg, 1'b0};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        act_next   = act_reg;
        err_next   = err_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        rhs_next   = rhs_reg;
        lhs_next   = lhs_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        we         = 1'b0;
        addr       = cnt_reg[PW-1:0];
        wd         = num_reg;
        push_val   = num_reg;
        push_en    = 1'b0;
        areq.start = 1'b0;
        areq.op    = pee_pkg::OP_DIV;
        areq.lhs   = lhs_reg;
        areq.rhs   = rhs_reg;

        if (ov_reg && m_axis_tready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    ch_next   = s_axis_tdata;
                    last_next = s_axis_tlast;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (is_digit) begin
                    num_next = num10[31:0] + {24'd0, ch_reg - pee_pkg::CH_ZERO};
                    act_next = 1'b1;
                    state_next = last_reg ? S_FLUSH : S_IDLE;
                    if (last_reg) begin
                        ch_next = pee_pkg::CH_SPACE;
                    end
                end else begin
                    if (act_reg) begin
                        push_en = 1'b1;
                    end
                    num_next = '0;
                    act_next = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (is_space) begin
                    state_next = last_reg ? S_TOP : S_IDLE;
                end else if (is_op) begin
                    if (cnt_reg < CW'(2)) begin
                        if (err_reg == pee_pkg::ERR_NONE) err_next = pee_pkg::ERR_UNDER;
                        state_next = last_reg ? S_TOP : S_IDLE;
                    end else begin
                        addr = PW'(cnt_reg - CW'(1));
                        state_next = S_RD1;
                    end
                end else begin
                    if (err_reg == pee_pkg::ERR_NONE) err_next = pee_pkg::ERR_CHAR;
                    state_next = last_reg ? S_TOP : S_IDLE;
                end
            end
            S_RD1: begin
                rhs_next = rd_data;
                addr = PW'(cnt_reg - CW'(2));
                state_next = S_RD2;
            end
            S_RD2: begin
                addr = PW'(cnt_reg - CW'(2));
                state_next = S_CALC;
            end
            S_CALC: begin
                lhs_next = rd_data;
                cnt_next = cnt_reg - CW'(2);
                unique case (ch_reg)
                    pee_pkg::CH_PLUS: begin
                        res_next = rd_data + rhs_reg;
                        state_next = S_PUSH;
                    end
                    pee_pkg::CH_MINUS: begin
                        res_next = rd_data - rhs_reg;
                        state_next = S_PUSH;
                    end
                    pee_pkg::CH_STAR: begin
                        state_next = S_WAIT;
                    end
                    pee_pkg::CH_SLASH: begin
                        if (rhs_reg == '0) begin
                            if (err_reg == pee_pkg::ERR_NONE) err_next = pee_pkg::ERR_DIV0;
                            res_next = '0;
                            state_next = S_PUSH;
                        end else begin
                            areq.start = 1'b1;
                            areq.op = pee_pkg::OP_DIV;
                            areq.lhs = rd_data;
                            state_next = S_WAIT;
                        end
                    end
                    default: begin
                        if (rhs_reg[31]) begin
                            state_next = S_PUSH;
                            if (rd_data == 32'd1) begin
                                res_next = 32'd1;
                            end else if (rd_data == 32'hFFFF_FFFF) begin
                                res_next = rhs_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                            end else begin
                                res_next = '0;
                                if (rd_data == '0 && err_reg == pee_pkg::ERR_NONE) begin
                                    err_next = pee_pkg::ERR_DIV0;
                                end
                            end
                        end else begin
                            areq.start = 1'b1;
                            areq.op = pee_pkg::OP_POW;
                            areq.lhs = rd_data;
                            state_next = S_WAIT;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                if (ch_reg == pee_pkg::CH_STAR) begin
                    res_next = prod[31:0];
                    state_next = S_PUSH;
                end else if (arsp.done) begin
                    res_next = arsp.result;
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                push_en = 1'b1;
                push_val = res_reg;
                state_next = last_reg ? S_TOP : S_IDLE;
            end
            S_TOP: begin
                if (!ov_reg || m_axis_tready) begin
                    addr = PW'(cnt_reg - CW'(1));
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                ov_next = 1'b1;
                if (cnt_reg == '0) begin
                    od_next = {5'd0,
                        (err_reg != pee_pkg::ERR_NONE) ? err_reg : pee_pkg::ERR_EMPTY, 32'd0};
                end else begin
                    od_next = {5'd0, err_reg, rd_data};
                end
                cnt_next = '0;
                num_next = '0;
                act_next = 1'b0;
                err_next = pee_pkg::ERR_NONE;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (push_en) begin
            if (cnt_reg >= CW'(pee_pkg::STACK_DEPTH)) begin
                if (err_reg == pee_pkg::ERR_NONE) err_next = pee_pkg::ERR_OVER;
            end else begin
                we = 1'b1;
                addr = cnt_reg[PW-1:0];
                wd = push_val;
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            num_reg   <= '0;
            act_reg   <= 1'b0;
            err_reg   <= pee_pkg::ERR_NONE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            num_reg   <= num_next;
            act_reg   <= act_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
        ch_reg   <= ch_next;
        last_reg <= last_next;
        rhs_reg  <= rhs_next;
        lhs_reg  <= lhs_next;
        res_reg  <= res_next;
        od_reg   <= od_next;
    end

endmodule

// ----- hw/rtl/pee_alu.sv -----
module pee_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  pee_pkg::alu_req_t req,
    output pee_pkg::alu_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_DIV  = 3'b010,
        A_POW  = 3'b100
    } alu_state_t;

    alu_state_t  state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] ex_reg, ex_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] mul_acc;
    logic [63:0] mul_sq;

    assign ua = req.lhs[31] ? 32'(0 - req.lhs) : req.lhs;
    assign ub = req.rhs[31] ? 32'(0 - req.rhs) : req.rhs;
    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign mul_acc = acc_reg * sq_reg;
    assign mul_sq  = sq_reg * sq_reg;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        ex_next    = ex_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    if (req.op == pee_pkg::OP_DIV) begin
                        state_next = A_DIV;
                        rem_next   = '0;
                        quo_next   = ua;
                        dvs_next   = ub;
                        neg_next   = req.lhs[31] ^ req.rhs[31];
                        step_next  = '0;
                    end else begin
                        state_next = A_POW;
                        acc_next   = 32'd1;
                        sq_next    = req.lhs;
                        ex_next    = req.rhs;
                    end
                end
            end
            A_DIV: begin
                if (!rem_sub[32]) begin
                    rem_next = rem_sub[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_sh[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31) begin
                    state_next = A_IDLE;
                    done_next  = 1'b1;
                    res_next   = neg_reg ? 32'(0 - quo_next) : quo_next;
                end
            end
            A_POW: begin
                if (ex_reg == '0) begin
                    state_next = A_IDLE;
                    done_next  = 1'b1;
                    res_next   = acc_reg;
                end else begin
                    if (ex_reg[0]) begin
                        acc_next = mul_acc[31:0];
                    end
                    sq_next = mul_sq[31:0];
                    ex_next = {1'b0, ex_reg[31:1]};
                end
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        ex_reg   <= ex_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  error;
    } rpn_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    logic [31:0] ops [pee_pkg::STACK_DEPTH];
    int          depth_now;
    logic [31:0] digits_acc;
    logic        digits_live;
    logic [2:0]  first_err;
    rpn_result_t result_q[$];
    int          mismatches;
    bit          all_sent;

    postfix_expression_evaluator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void raise_err(logic [2:0] e);
        if (first_err == pee_pkg::ERR_NONE) first_err = e;
    endfunction

    function automatic void push_op(logic [31:0] v);
        if (depth_now >= pee_pkg::STACK_DEPTH) begin
            raise_err(pee_pkg::ERR_OVER);
        end else begin
            ops[depth_now] = v;
            depth_now++;
        end
    endfunction

    function automatic void flush_digits();
        if (digits_live) push_op(digits_acc);
        digits_acc = 32'd0;
        digits_live = 1'b0;
    endfunction

    function automatic logic [31:0] quot(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] ipow(logic [31:0] b, logic [31:0] e);
        logic [31:0] acc, sq;
        acc = 32'd1;
        sq = b;
        if (e[31]) begin
            if (b == 32'd1) return 32'd1;
            if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
            if (b == 32'd0) raise_err(pee_pkg::ERR_DIV0);
            return 32'd0;
        end
        while (e != 0) begin
            if (e[0]) acc = acc * sq;
            sq = sq * sq;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic void apply_op(logic [7:0] c);
        logic [31:0] l, r, y;
        if (depth_now < 2) begin
            raise_err(pee_pkg::ERR_UNDER);
            return;
        end
        r = ops[depth_now-1];
        l = ops[depth_now-2];
        depth_now -= 2;
        case (c)
            pee_pkg::CH_PLUS:  y = l + r;
            pee_pkg::CH_MINUS: y = l - r;
            pee_pkg::CH_STAR:  y = l * r;
            pee_pkg::CH_SLASH: begin
                if (r == 0) begin
                    raise_err(pee_pkg::ERR_DIV0);
                    y = 32'd0;
                end else begin
                    y = quot(l, r);
                end
            end
            default:  y = ipow(l, r);
        endcase
        push_op(y);
    endfunction

    function automatic void predict_char(logic [7:0] c, logic lst);
        rpn_result_t res;
        if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) begin
            digits_acc = digits_acc * 10 + 32'(c - pee_pkg::CH_ZERO);
            digits_live = 1'b1;
        end else begin
            flush_digits();
            if (c == pee_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
            end else if (c == pee_pkg::CH_PLUS || c == pee_pkg::CH_MINUS ||
                         c == pee_pkg::CH_STAR || c == pee_pkg::CH_SLASH ||
                         c == pee_pkg::CH_CARET) begin
                apply_op(c);
            end else begin
                raise_err(pee_pkg::ERR_CHAR);
            end
        end
        if (!lst) return;
        flush_digits();
        if (depth_now == 0) begin
            res.value = 32'd0;
            res.error = (first_err != pee_pkg::ERR_NONE) ? first_err : pee_pkg::ERR_EMPTY;
        end else begin
            res.value = ops[depth_now-1];
            res.error = first_err;
        end
        result_q.push_back(res);
        depth_now = 0;
        first_err = pee_pkg::ERR_NONE;
    endfunction

    task automatic send_char(logic [7:0] c, logic lst);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= lst;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_char(c, lst);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // result side stalls and compare
    initial begin
        int stall;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", m_axis_tdata);
            end else begin
                rpn_result_t e;
                e = result_q.pop_front();
                if (m_axis_tdata[31:0] !== e.value || m_axis_tdata[34:32] !== e.error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %h err %0d, got value %h err %0d",
                                 e.value, e.error, m_axis_tdata[31:0], m_axis_tdata[34:32]);
                end
            end
        end
    end

    task automatic test_directed();
        send_text("3 4 +");
        send_text("10 3 -");
        send_text("4294967295 7 *");
        send_text("7 2 /");
        send_text("2147483648 0 1 - /");
        send_text("5 0 /");
        send_text("2 10 ^");
        send_text("0 0 ^");
        send_text("0 0 1 - ^");
        send_text("0 1 - 0 3 - ^");
        send_text("1 0 1 - ^");
        send_text("9 0 5 - ^");
        send_text("1 +");
        send_text("1 a 2");
        send_text(" ");
        send_text("12\t\n\v\f\r3 *");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'h39, 1'b1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < pee_pkg::STACK_DEPTH + 2; i++) begin
            send_char(8'h31, 1'b0);
            send_char(pee_pkg::CH_SPACE, 1'b0);
        end
        send_char(pee_pkg::CH_PLUS, 1'b1);
    endtask

    task automatic test_random();
        int n, k, len;
        logic [7:0] opset [5];
        opset = '{pee_pkg::CH_PLUS, pee_pkg::CH_MINUS, pee_pkg::CH_STAR,
                  pee_pkg::CH_SLASH, pee_pkg::CH_CARET};
        n = 0;
        while (n < 640) begin
            if ($urandom_range(0, 4) != 0) begin
                // well-formed expression with random operands
                k = $urandom_range(1, 5);
                for (int i = 0; i < k; i++) begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 11)
                                                      : $urandom_range(1, 3);
                    for (int j = 0; j < len; j++) begin
                        send_char(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                        n++;
                    end
                    send_char(pee_pkg::CH_SPACE, 1'b0);
                    n++;
                    if (i > 0) begin
                        send_char(opset[$urandom_range(0, 4)], 1'b0);
                        n++;
                    end
                end
                send_char(pee_pkg::CH_SPACE, 1'b1);
                n++;
            end else begin
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++) begin
                    send_char(8'($urandom_range(0, 255)), j == len - 1);
                    n++;
                end
            end
        end
    endtask

    initial begin
        depth_now = 0;
        digits_acc = 32'd0;
        digits_live = 1'b0;
        first_err = pee_pkg::ERR_NONE;
        mismatches = 0;
        all_sent = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_random();
        s_axis_tvalid <= 1'b0;
        all_sent = 1'b1;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("postfix_expression_evaluator verification clean");
        end else begin
            $display("postfix_expression_evaluator verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("postfix_expression_evaluator verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pee_pkg.sv
hw/rtl/pee_alu.sv
hw/rtl/postfix_expression_evaluator.sv
bench/tb_top.sv
